// File: src/bpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared codes and control types for the bounded priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP_HEAD  = 2'd1,
    OP_REMOVE_AT = 2'd2,
    OP_RESERVED  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic {
    CFG_MAX_LEN    = 1'b0,
    CFG_ORDER_MODE = 1'b1
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 5;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic push;       // insert the new entry this cycle
    logic remove;     // remove the entry at the broadcast position
    logic prio_mode;  // ascending priority insertion when set
  } cell_ctrl_t;

endpackage : bpq_pkg
`default_nettype wire

// File: src/bpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the queue: holds a tag and a priority, compares against the
// incoming priority and takes its next value from itself, a neighbor or the
// new entry.
// ----------------------------------------------------------------------------
module bpq_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned CW         = 5,
  parameter int unsigned PRIO_WIDTH = 16
) (
  input  wire                         clk,
  input  wire bpq_pkg::cell_ctrl_t    ctrl,
  input  wire logic [CW-1:0]          count,
  input  wire logic [CW-1:0]          pos,
  input  wire logic [31:0]            new_tag,
  input  wire logic [PRIO_WIDTH-1:0]  new_prio,
  input  wire logic [31:0]            left_tag,
  input  wire logic [PRIO_WIDTH-1:0]  left_prio,
  input  wire logic [31:0]            right_tag,
  input  wire logic [PRIO_WIDTH-1:0]  right_prio,
  input  wire logic                   gt_in,
  input  wire logic                   ins_in,
  input  wire logic [31:0]            rem_in,
  output logic [31:0]                 tag,
  output logic [PRIO_WIDTH-1:0]       prio,
  output logic                        gt_out,
  output logic                        ins_out,
  output logic [31:0]                 rem_out
);

  localparam logic [CW-1:0] IDX_V = CW'(IDX);

  logic [31:0]           tag_r, tag_nxt;
  logic [PRIO_WIDTH-1:0] prio_r, prio_nxt;
  logic                  occupied;
  logic                  gt;
  logic                  ins;

  // slot holds a live entry
  assign occupied = IDX_V < count;

  // first strictly greater priority marks the insertion point
  assign gt      = ctrl.prio_mode & occupied & ($signed(prio_r) > $signed(new_prio));
  assign gt_out  = gt_in | gt;
  assign ins     = gt_out | ~occupied;
  assign ins_out = ins;

  // removed tag travels toward the head
  assign rem_out = (IDX_V == pos) ? tag_r : rem_in;

  // next slot contents
  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    if (ctrl.push) begin
      if (ins && !ins_in) begin
        tag_nxt  = new_tag;
        prio_nxt = new_prio;
      end else if (ins) begin
        tag_nxt  = left_tag;
        prio_nxt = left_prio;
      end
    end else if (ctrl.remove) begin
      if (IDX_V >= pos) begin
        tag_nxt  = right_tag;
        prio_nxt = right_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign tag  = tag_r;
  assign prio = prio_r;

endmodule : bpq_cell
`default_nettype wire

// File: src/bounded_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Ordered (tag, priority) queue built as a row of slots with push, pop head
// and remove at position.
// ----------------------------------------------------------------------------
// Each operation completes on acceptance: each slot compares its priority with
// the incoming one and shifts, loads or holds in the same cycle, so a word is
// accepted every cycle as long as the result register is free or being
// drained. The result is registered and reports the head and occupancy after
// the operation in the cycle after acceptance. The insertion point is found by
// an OR chain across the slots, which sets the clock path for large DEPTH.
// Configuration is written through cfg_we/cfg_index/cfg_wdata with no wait.
// ----------------------------------------------------------------------------
module bounded_priority_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned PRIO_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_tag,
  input  wire logic [15:0] in_priority_req,
  input  wire logic [3:0]  in_position,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic             out_head_valid,
  output logic [31:0]      out_head_tag,
  output logic [15:0]      out_head_priority,
  output logic [31:0]      out_removed_tag,
  output logic [4:0]       out_occupancy,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned LW    = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  // configuration registers
  logic [4:0]       max_len_r;
  logic             order_mode_r;

  // occupancy and result registers
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic             out_ok_r;
  logic [31:0]      out_removed_r;

  logic             in_fire;
  logic [LW-1:0]    count_l;
  logic [LW-1:0]    limit;
  logic [CW-1:0]    count_c;
  logic [CW-1:0]    rm_pos;
  logic             op_ok;
  logic             do_push;
  logic             do_remove;
  logic [31:0]      req_ext;
  logic [PRIO_WIDTH-1:0] new_prio;
  logic [31:0]      head_prio_ext;
  bpq_pkg::cell_ctrl_t ctrl;

  // slot row wiring
  logic [31:0]           cell_tag   [DEPTH];
  logic [PRIO_WIDTH-1:0] cell_prio  [DEPTH];
  logic [31:0]           left_tag   [DEPTH];
  logic [PRIO_WIDTH-1:0] left_prio  [DEPTH];
  logic [31:0]           right_tag  [DEPTH];
  logic [PRIO_WIDTH-1:0] right_prio [DEPTH];
  logic [DEPTH:0]        gt_chain;
  logic [DEPTH:0]        ins_chain;
  logic [31:0]           rem_chain  [DEPTH+1];

  assign in_fire  = in_valid & in_ready;
  assign in_ready = ~out_valid_r | out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= '0;
      order_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (bpq_pkg::cfg_idx_t'(cfg_index))
        bpq_pkg::CFG_MAX_LEN:    max_len_r    <= cfg_wdata;
        bpq_pkg::CFG_ORDER_MODE: order_mode_r <= cfg_wdata[0];
        default:                 max_len_r    <= max_len_r;
      endcase
    end
  end

  // push limit and operation check
  assign count_l = LW'(count_r);
  assign count_c = CW'(count_r);
  assign limit   = (max_len_r == 5'd0 || LW'(max_len_r) > DEPTH_L) ? DEPTH_L
                                                                  : LW'(max_len_r);

  always_comb begin
    op_ok     = 1'b0;
    do_push   = 1'b0;
    do_remove = 1'b0;
    rm_pos    = CW'(in_position);
    count_nxt = count_r;
    case (bpq_pkg::op_t'(in_op))
      bpq_pkg::OP_PUSH: begin
        op_ok   = count_l < limit;
        do_push = op_ok;
      end
      bpq_pkg::OP_POP_HEAD: begin
        rm_pos    = '0;
        op_ok     = count_r != '0;
        do_remove = op_ok;
      end
      bpq_pkg::OP_REMOVE_AT: begin
        op_ok     = CW'(in_position) < count_c;
        do_remove = op_ok;
      end
      default: op_ok = 1'b0;
    endcase
    if (in_fire && do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (in_fire && do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign ctrl.push      = in_fire & do_push;
  assign ctrl.remove    = in_fire & do_remove;
  assign ctrl.prio_mode = order_mode_r;

  // priority kept at its stored width
  assign req_ext  = 32'(signed'(in_priority_req));
  assign new_prio = req_ext[PRIO_WIDTH-1:0];

  // chain ends
  assign gt_chain[0]      = 1'b0;
  assign ins_chain[0]     = 1'b0;
  assign rem_chain[DEPTH] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_tag[gi]  = in_tag;
        assign left_prio[gi] = new_prio;
      end else begin : g_mid
        assign left_tag[gi]  = cell_tag[gi-1];
        assign left_prio[gi] = cell_prio[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_tag[gi]  = cell_tag[gi];
        assign right_prio[gi] = cell_prio[gi];
      end else begin : g_inner
        assign right_tag[gi]  = cell_tag[gi+1];
        assign right_prio[gi] = cell_prio[gi+1];
      end

      bpq_cell #(
        .IDX        (gi),
        .CW         (CW),
        .PRIO_WIDTH (PRIO_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_c),
        .pos        (rm_pos),
        .new_tag    (in_tag),
        .new_prio   (new_prio),
        .left_tag   (left_tag[gi]),
        .left_prio  (left_prio[gi]),
        .right_tag  (right_tag[gi]),
        .right_prio (right_prio[gi]),
        .gt_in      (gt_chain[gi]),
        .ins_in     (ins_chain[gi]),
        .rem_in     (rem_chain[gi+1]),
        .tag        (cell_tag[gi]),
        .prio       (cell_prio[gi]),
        .gt_out     (gt_chain[gi+1]),
        .ins_out    (ins_chain[gi+1]),
        .rem_out    (rem_chain[gi])
      );
    end
  endgenerate

  // occupancy and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ok_r      <= op_ok;
      out_removed_r <= do_remove ? rem_chain[0] : 32'd0;
    end
  end

  // head is read from the first slot, state holds while the result waits
  assign head_prio_ext     = 32'($signed(cell_prio[0]));
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_head_valid    = count_r != '0;
  assign out_head_tag      = (count_r != '0) ? cell_tag[0] : 32'd0;
  assign out_head_priority = (count_r != '0) ? head_prio_ext[15:0] : 16'd0;
  assign out_removed_tag   = out_removed_r;
  assign out_occupancy     = count_l[4:0];

  // checks
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above capacity");

  a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow occupancy");

  a_refused_holds : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !op_ok |=> count_r == $past(count_r) && !out_ok)
    else $error("refused operation changed occupancy");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule : bounded_priority_queue
`default_nettype wire

// File: tb/bounded_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// bounded_priority_queue_tb
// Self-checking bench for the bounded priority queue. A shadow queue in the
// bench tracks every accepted word and predicts the head report that comes
// back for it; each report is compared field by field. A short directed table
// covers empty, full, bad position, unused op and tie cases, then random
// phases sweep the limit and order registers with random idling on both sides.
// ----------------------------------------------------------------------------
module bounded_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned PRIO_W      = 16;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 175;
  localparam logic [4:0] PHASE_LIMIT [PHASES] = '{5'd0, 5'd16, 5'd1, 5'd31,
                                                  5'd3, 5'd16, 5'd0, 5'd8};
  localparam logic PHASE_SORTED [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                            1'b1, 1'b1, 1'b0, 1'b1};

  // one head report as seen on the result channel
  typedef struct packed {
    logic        ok;
    logic        head_valid;
    logic [31:0] head_tag;
    logic [15:0] head_prio;
    logic [31:0] removed_tag;
    logic [4:0]  occupancy;
  } head_report_t;

  // one row of the directed table: a register write or an input word
  typedef struct {
    logic               is_setting;
    bpq_pkg::cfg_idx_t  sel;
    logic [4:0]         val;
    bpq_pkg::op_t       op;
    logic [31:0]        tag;
    logic [15:0]        prio;
    logic [3:0]         pos;
    logic               typed;
    head_report_t       want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [31:0] in_tag = '0;
  logic [15:0] in_priority_req = '0;
  logic [3:0]  in_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_ok;
  logic        out_head_valid;
  logic [31:0] out_head_tag;
  logic [15:0] out_head_priority;
  logic [31:0] out_removed_tag;
  logic [4:0]  out_occupancy;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the queue and its registers
  logic [31:0]        shadow_tag  [SLOTS];
  logic signed [15:0] shadow_prio [SLOTS];
  int                 shadow_fill = 0;
  logic [4:0]         shadow_limit = '0;
  logic               shadow_sorted = 1'b0;

  head_report_t awaited_reports [$];
  plan_row_t    directed_plan [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  logic         steady = 1'b0;

  bounded_priority_queue #(
    .DEPTH      (SLOTS),
    .PRIO_WIDTH (PRIO_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_tag            (in_tag),
    .in_priority_req   (in_priority_req),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_head_valid    (out_head_valid),
    .out_head_tag      (out_head_tag),
    .out_head_priority (out_head_priority),
    .out_removed_tag   (out_removed_tag),
    .out_occupancy     (out_occupancy),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // close the gap left by a removed slot and return its tag
  function automatic logic [31:0] take_slot(input int at);
    logic [31:0] gone;
    gone = shadow_tag[at];
    for (int i = at; i + 1 < shadow_fill; i++) begin
      shadow_tag[i]  = shadow_tag[i + 1];
      shadow_prio[i] = shadow_prio[i + 1];
    end
    shadow_fill--;
    return gone;
  endfunction

  // apply one accepted word to the shadow queue and build its head report
  task automatic step_shadow_queue(input bpq_pkg::op_t op, input logic [31:0] tag,
                                   input logic signed [15:0] prio,
                                   input logic [3:0] pos, output head_report_t rep);
    int at;
    int cap;
    logic done;
    logic [31:0] gone;
    done = 1'b0;
    gone = '0;
    cap = (shadow_limit == 0 || shadow_limit > SLOTS) ? SLOTS : int'(shadow_limit);
    case (op)
      bpq_pkg::OP_PUSH: begin
        if (shadow_fill < cap) begin
          at = shadow_fill;
          // first slot holding a strictly greater priority
          if (shadow_sorted) begin
            for (int i = shadow_fill - 1; i >= 0; i--)
              if (shadow_prio[i] > prio) at = i;
          end
          for (int i = shadow_fill; i > at; i--) begin
            shadow_tag[i]  = shadow_tag[i - 1];
            shadow_prio[i] = shadow_prio[i - 1];
          end
          shadow_tag[at]  = tag;
          shadow_prio[at] = prio;
          shadow_fill++;
          done = 1'b1;
        end
      end
      bpq_pkg::OP_POP_HEAD: begin
        if (shadow_fill > 0) begin
          gone = take_slot(0);
          done = 1'b1;
        end
      end
      bpq_pkg::OP_REMOVE_AT: begin
        if (int'(pos) < shadow_fill) begin
          gone = take_slot(int'(pos));
          done = 1'b1;
        end
      end
      default: ;
    endcase
    rep.ok          = done;
    rep.head_valid  = (shadow_fill > 0);
    rep.head_tag    = (shadow_fill > 0) ? shadow_tag[0] : 32'd0;
    rep.head_prio   = (shadow_fill > 0) ? shadow_prio[0] : 16'd0;
    rep.removed_tag = gone;
    rep.occupancy   = 5'(shadow_fill);
  endtask

  // directed table builders
  task automatic add_setting(input bpq_pkg::cfg_idx_t sel, input logic [4:0] val);
    plan_row_t row;
    row.is_setting = 1'b1;
    row.sel        = sel;
    row.val        = val;
    row.op         = bpq_pkg::OP_PUSH;
    row.tag        = '0;
    row.prio       = '0;
    row.pos        = '0;
    row.typed      = 1'b0;
    row.want       = '0;
    directed_plan.push_back(row);
  endtask

  task automatic add_word(input bpq_pkg::op_t op, input logic [31:0] tag,
                          input logic [15:0] prio,
                          input logic [3:0] pos, input logic typed,
                          input head_report_t want);
    plan_row_t row;
    row.is_setting = 1'b0;
    row.sel        = bpq_pkg::CFG_MAX_LEN;
    row.val        = '0;
    row.op         = op;
    row.tag        = tag;
    row.prio       = prio;
    row.pos        = pos;
    row.typed      = typed;
    row.want       = want;
    directed_plan.push_back(row);
  endtask

  // hold off the sender until every report has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  // register write while the queue is idle
  task automatic write_setting(input bpq_pkg::cfg_idx_t sel, input logic [4:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    if (sel == bpq_pkg::CFG_MAX_LEN) shadow_limit = val;
    else shadow_sorted = val[0];
  endtask

  // offer one word, wait for acceptance, then record its expected report
  task automatic send_word(input bpq_pkg::op_t op, input logic [31:0] tag,
                           input logic [15:0] prio,
                           input logic [3:0] pos, input logic typed,
                           input head_report_t want);
    head_report_t rep;
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_tag          <= tag;
    in_priority_req <= prio;
    in_position     <= pos;
    do @(posedge clk); while (!in_ready);
    step_shadow_queue(op, tag, prio, pos, rep);
    awaited_reports.push_back(typed ? want : rep);
  endtask

  // stimulus
  initial begin : stimulus
    bpq_pkg::op_t op;
    logic [31:0] tag;
    logic [15:0] prio;
    logic [3:0] pos;
    int pick;
    int push_pct;

    // empty queue, extremes, bad positions, unused op, fifo order
    add_word(bpq_pkg::OP_POP_HEAD, 32'h0, 16'h0, 4'd0, 1'b1, '0);
    add_word(bpq_pkg::OP_REMOVE_AT, 32'h0, 16'h0, 4'd0, 1'b1, '0);
    add_word(bpq_pkg::OP_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b1, '0);
    add_word(bpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 16'h7FFF, 4'd0, 1'b1,
             '{1'b1, 1'b1, 32'hFFFF_FFFF, 16'h7FFF, 32'd0, 5'd1});
    add_word(bpq_pkg::OP_PUSH, 32'h0000_0000, 16'h8000, 4'hF, 1'b0, '0);
    add_word(bpq_pkg::OP_PUSH, 32'hA5A5_5A5A, 16'h0001, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_REMOVE_AT, 32'h0, 16'h0, 4'd3, 1'b0, '0);
    add_word(bpq_pkg::OP_REMOVE_AT, 32'h0, 16'h0, 4'hF, 1'b0, '0);
    add_word(bpq_pkg::OP_REMOVE_AT, 32'h0, 16'h0, 4'd1, 1'b0, '0);
    add_word(bpq_pkg::OP_RESERVED, 32'h1234_5678, 16'h1234, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_POP_HEAD, 32'h0, 16'h0, 4'd0, 1'b0, '0);
    // small limit, push refused when full
    add_setting(bpq_pkg::CFG_MAX_LEN, 5'd2);
    add_word(bpq_pkg::OP_PUSH, 32'h5A5A_A5A5, 16'hFFFF, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_PUSH, 32'h0000_0001, 16'h0000, 4'd0, 1'b0, '0);
    // priority insertion, limit above capacity, equal priorities
    add_setting(bpq_pkg::CFG_ORDER_MODE, 5'd1);
    add_setting(bpq_pkg::CFG_MAX_LEN, 5'd31);
    add_word(bpq_pkg::OP_PUSH, 32'h1111_1111, 16'h7FFF, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_PUSH, 32'h2222_2222, 16'h8000, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_PUSH, 32'h3333_3333, 16'h0000, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_PUSH, 32'h4444_4444, 16'h0000, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_PUSH, 32'h5555_5555, 16'hFFFF, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_REMOVE_AT, 32'h0, 16'h0, 4'd6, 1'b0, '0);
    add_word(bpq_pkg::OP_REMOVE_AT, 32'h0, 16'h0, 4'd0, 1'b0, '0);
    add_setting(bpq_pkg::CFG_MAX_LEN, 5'd16);
    repeat (5) add_word(bpq_pkg::OP_POP_HEAD, 32'h0, 16'h0, 4'd0, 1'b0, '0);
    add_word(bpq_pkg::OP_POP_HEAD, 32'h0, 16'h0, 4'd0, 1'b1, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_setting) begin
        write_setting(directed_plan[k].sel, directed_plan[k].val);
      end else begin
        send_word(directed_plan[k].op, directed_plan[k].tag, directed_plan[k].prio,
                  directed_plan[k].pos, directed_plan[k].typed, directed_plan[k].want);
      end
    end

    // random phases over limit and order settings
    push_pct = 50;
    for (int p = 0; p < PHASES; p++) begin
      write_setting(bpq_pkg::CFG_MAX_LEN, PHASE_LIMIT[p]);
      write_setting(bpq_pkg::CFG_ORDER_MODE, {4'd0, PHASE_SORTED[p]});
      steady = (p == 3);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // alternate filling and draining runs
        if (i % 35 == 0) begin
          case ($urandom_range(0, 2))
            0:       push_pct = 75;
            1:       push_pct = 50;
            default: push_pct = 30;
          endcase
        end
        if (i == 100) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < push_pct) op = bpq_pkg::OP_PUSH;
        else if (pick < push_pct + (100 - push_pct) / 2) op = bpq_pkg::OP_POP_HEAD;
        else if (pick < 97) op = bpq_pkg::OP_REMOVE_AT;
        else op = bpq_pkg::OP_RESERVED;
        case ($urandom_range(0, 9))
          0:       tag = 32'h0000_0000;
          1:       tag = 32'hFFFF_FFFF;
          default: tag = $urandom;
        endcase
        // extremes and a narrow band for ties
        case ($urandom_range(0, 9))
          0:       prio = 16'h8000;
          1:       prio = 16'h7FFF;
          2, 3:    prio = 16'($urandom_range(0, 6) - 3);
          default: prio = 16'($urandom);
        endcase
        if (shadow_fill > 0 && $urandom_range(0, 99) < 80)
          pos = 4'($urandom_range(0, shadow_fill - 1));
        else
          pos = 4'($urandom);
        send_word(op, tag, prio, pos, 1'b0, '0);
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("bounded_priority_queue_tb: PASS");
    end else begin
      $display("bounded_priority_queue_tb: FAIL");
    end
    $finish;
  end

  // result side: compare each report with the oldest expectation
  always @(posedge clk) begin : result_check
    head_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        $error("result word with no expectation waiting");
        error_count++;
      end else begin
        want = awaited_reports.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          error_count++;
        end
        if (out_head_valid !== want.head_valid) begin
          $error("head_valid: expected %0d, got %0d", want.head_valid, out_head_valid);
          error_count++;
        end
        if (out_head_tag !== want.head_tag) begin
          $error("head_tag: expected %h, got %h", want.head_tag, out_head_tag);
          error_count++;
        end
        if (out_head_priority !== want.head_prio) begin
          $error("head_priority: expected %0d, got %0d",
                 $signed(want.head_prio), $signed(out_head_priority));
          error_count++;
        end
        if (out_removed_tag !== want.removed_tag) begin
          $error("removed_tag: expected %h, got %h", want.removed_tag, out_removed_tag);
          error_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_occupancy);
          error_count++;
        end
      end
    end
    out_ready <= steady || ($urandom_range(0, 99) >= 26);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bounded_priority_queue_tb: FAIL");
      $finish;
    end
  end

endmodule

// File: filelist.f
src/bpq_pkg.sv
src/bpq_cell.sv
src/bounded_priority_queue.sv
tb/bounded_priority_queue_tb.sv
